>>> hdl/task_execution_time_stats_defines.svh
// Assertion macros shared by the task execution time monitor.
`ifndef TASK_EXECUTION_TIME_STATS_DEFINES_SVH
`define TASK_EXECUTION_TIME_STATS_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TETS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TETS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tets_pkg.sv
// Shared constants, types and helper functions of the task execution time monitor.
package tets_pkg;

  localparam int TASK_COUNT  = 64;
  localparam int RING_DEPTH  = 16;
  localparam int TASK_W      = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int SLOT_W      = $clog2(RING_DEPTH);
  localparam int UNREAD_W    = $clog2(RING_DEPTH + 1);
  localparam int RING_AW     = TASK_W + SLOT_W;
  localparam int TBL_MAX     = (RING_DEPTH - 1 < 15) ? RING_DEPTH - 1 : 15;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int APB_AW      = 4;
  localparam int APB_DW      = 64;
  localparam int MASK_W      = 64;

  localparam logic [2:0] MODE_SLICE = 3'd0;
  localparam logic [2:0] MODE_END   = 3'd1;
  localparam logic [2:0] MODE_GET   = 3'd2;
  localparam logic [2:0] MODE_CLR   = 3'd3;
  localparam logic [2:0] MODE_TBL   = 3'd4;

  localparam logic REG_MASK = 1'b0;

  typedef enum logic [2:0] {
    OP_SLICE = 3'd0,
    OP_END   = 3'd1,
    OP_GET   = 3'd2,
    OP_CLR   = 3'd3,
    OP_TBL   = 3'd4,
    OP_ERR   = 3'd5
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [TASK_W-1:0]  task_idx;
    logic [31:0]        amount;
    logic signed [4:0]  table_count;
  } job_t;

  typedef struct packed {
    logic [63:0]         sum;
    logic [31:0]         tmax;
    logic [31:0]         count;
    logic [SLOT_W-1:0]   ptr;
    logic [UNREAD_W-1:0] unread;
  } task_row_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

endpackage

>>> hdl/tets_ifs.sv
// Valid/ready channel interfaces for input words and result words.
interface tets_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic [7:0]        task_req;
  logic [31:0]       time_amount;
  logic signed [4:0] table_count;

  modport source (output valid, mode, task_req, time_amount, table_count, input ready);
  modport sink (input valid, mode, task_req, time_amount, table_count, output ready);
endinterface

interface tets_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [63:0] time_sum;
  logic [31:0] time_max;
  logic [31:0] job_count;
  logic [31:0] current_time;
  logic [31:0] entry_value;
  logic [3:0]  entry_total;
  logic        last;

  modport source (output valid, status, time_sum, time_max, job_count, current_time,
                  entry_value, entry_total, last, input ready);
  modport sink (input valid, status, time_sum, time_max, job_count, current_time,
                entry_value, entry_total, last, output ready);
endinterface

>>> hdl/tets_front.sv
// Front end: enable mask register, APB port, and classification of input words.
module tets_front (
  input  logic                       clk,
  input  logic                       rst_n,
  tets_in_if.sink                    in_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tets_pkg::APB_AW-1:0] paddr,
  input  logic [tets_pkg::APB_DW-1:0] pwdata,
  output logic [tets_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  input  tets_pkg::back_stat_t       stat,
  input  logic                       q_ready,
  output logic                       q_push,
  output tets_pkg::job_t             q_job
);

  logic [tets_pkg::MASK_W-1:0] mask_r, mask_nxt;
  logic                        task_ok;
  logic                        keep;
  tets_pkg::op_t               op;

  assign pready = 1'b1;
  assign prdata = (paddr[tets_pkg::APB_AW-1] == tets_pkg::REG_MASK) ? mask_r : '0;

  always_comb begin
    mask_nxt = mask_r;
    if (psel && penable && pwrite && (paddr[tets_pkg::APB_AW-1] == tets_pkg::REG_MASK)) begin
      mask_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  assign task_ok = (in_ch.task_req < 8'(tets_pkg::TASK_COUNT)) && mask_r[in_ch.task_req[5:0]];

  always_comb begin
    op   = tets_pkg::OP_ERR;
    keep = 1'b0;
    case (in_ch.mode)
      tets_pkg::MODE_SLICE: begin
        op   = tets_pkg::OP_SLICE;
        keep = task_ok;
      end
      tets_pkg::MODE_END: begin
        op   = tets_pkg::OP_END;
        keep = task_ok;
      end
      tets_pkg::MODE_GET: begin
        op   = task_ok ? tets_pkg::OP_GET : tets_pkg::OP_ERR;
        keep = 1'b1;
      end
      tets_pkg::MODE_CLR: begin
        op   = task_ok ? tets_pkg::OP_CLR : tets_pkg::OP_ERR;
        keep = 1'b1;
      end
      tets_pkg::MODE_TBL: begin
        op   = task_ok ? tets_pkg::OP_TBL : tets_pkg::OP_ERR;
        keep = 1'b1;
      end
      default: begin
        op   = tets_pkg::OP_ERR;
        keep = 1'b0;
      end
    endcase
  end

  assign in_ch.ready       = q_ready && !stat.clearing;
  assign q_push            = in_ch.valid && in_ch.ready && keep;
  assign q_job.op          = op;
  assign q_job.task_idx    = in_ch.task_req[tets_pkg::TASK_W-1:0];
  assign q_job.amount      = in_ch.time_amount;
  assign q_job.table_count = in_ch.table_count;

endmodule

>>> hdl/tets_queue.sv
// Short FIFO of classified jobs between the front end and the back end.
module tets_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tets_pkg::job_t push_job,
  output logic           ready,
  input  logic           pop,
  output logic           valid,
  output tets_pkg::job_t head
);

  tets_pkg::job_t                mem_r [tets_pkg::QUEUE_DEPTH];
  logic [tets_pkg::QPTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [tets_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign ready = (cnt_r != tets_pkg::QCNT_W'(tets_pkg::QUEUE_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == tets_pkg::QPTR_W'(tets_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == tets_pkg::QPTR_W'(tets_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

endmodule

>>> hdl/tets_back.sv
// Back end: per-task statistics memory, time ring memory, sequencer and result register.
module tets_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  tets_pkg::job_t       q_job,
  output logic                 q_pop,
  output tets_pkg::back_stat_t stat,
  tets_out_if.source           out_ch
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_TROW   = 5'b00100,
    ST_RING   = 5'b01000,
    ST_STREAM = 5'b10000
  } state_t;

  state_t                            state_r, state_nxt;
  tets_pkg::job_t                    job_r, job_nxt;
  logic [tets_pkg::SLOT_W-1:0]       idx_r, idx_nxt;
  logic [3:0]                        n_r, n_nxt;
  logic [3:0]                        k_r, k_nxt;
  logic [tets_pkg::RING_AW-1:0]      clr_r, clr_nxt;

  tets_pkg::task_row_t               tmem [tets_pkg::TASK_COUNT];
  tets_pkg::task_row_t               trow_q;
  logic [tets_pkg::TASK_W-1:0]       t_rd_addr, t_wr_addr;
  logic                              t_we;
  tets_pkg::task_row_t               t_wdata;

  logic [31:0]                       rmem [2**tets_pkg::RING_AW];
  logic [31:0]                       ring_q;
  logic [tets_pkg::SLOT_W-1:0]       rd_slot;
  logic [tets_pkg::RING_AW-1:0]      r_rd_addr, r_wr_addr;
  logic                              r_we;
  logic [31:0]                       r_wdata;

  logic                              ov_r, ostat_r, olast_r;
  logic [63:0]                       osum_r;
  logic [31:0]                       omax_r, ocnt_r, ocur_r, oval_r;
  logic [3:0]                        otot_r;
  logic                              load, out_free;
  logic                              ld_stat, ld_last;
  logic [63:0]                       ld_sum;
  logic [31:0]                       ld_max, ld_cnt, ld_cur, ld_val;
  logic [3:0]                        ld_tot;

  logic [tets_pkg::SLOT_W-1:0]       cur, nxt_slot, start;
  logic [32:0]                       slice_sum;
  logic [64:0]                       end_sum;
  logic [7:0]                        n_wide, s_wide;
  logic [3:0]                        n_tbl;

  assign out_free = !ov_r || out_ch.ready;
  assign cur      = trow_q.ptr;
  assign nxt_slot = tets_pkg::slot_inc(cur);
  assign slice_sum = {1'b0, ring_q} + {1'b0, job_r.amount};
  assign end_sum   = {1'b0, trow_q.sum} + 65'(ring_q);
  assign n_wide    = job_r.table_count[4] ? 8'(trow_q.unread) : 8'(job_r.table_count[3:0]);
  assign n_tbl     = (n_wide > 8'(tets_pkg::TBL_MAX)) ? 4'(tets_pkg::TBL_MAX) : n_wide[3:0];
  assign s_wide    = (8'(cur) >= 8'(n_tbl)) ? 8'(cur) - 8'(n_tbl)
                                            : 8'(cur) + 8'(tets_pkg::RING_DEPTH) - 8'(n_tbl);
  assign start     = s_wide[tets_pkg::SLOT_W-1:0];
  assign stat.clearing = (state_r == ST_CLEAR);

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    clr_nxt   = clr_r;
    q_pop     = 1'b0;
    t_rd_addr = job_r.task_idx;
    t_we      = 1'b0;
    t_wr_addr = job_r.task_idx;
    t_wdata   = trow_q;
    rd_slot   = idx_r;
    r_we      = 1'b0;
    r_wr_addr = {job_r.task_idx, cur};
    r_wdata   = '0;
    load      = 1'b0;
    ld_stat   = 1'b0;
    ld_last   = 1'b1;
    ld_sum    = '0;
    ld_max    = '0;
    ld_cnt    = '0;
    ld_cur    = '0;
    ld_val    = '0;
    ld_tot    = '0;
    case (state_r)
      ST_CLEAR: begin
        r_we      = 1'b1;
        r_wr_addr = clr_r;
        t_wr_addr = clr_r[tets_pkg::TASK_W-1:0];
        t_wdata   = '0;
        t_we      = (clr_r < tets_pkg::RING_AW'(tets_pkg::TASK_COUNT));
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        t_rd_addr = q_job.task_idx;
        if (q_valid) begin
          q_pop     = 1'b1;
          job_nxt   = q_job;
          state_nxt = ST_TROW;
        end
      end
      ST_TROW: begin
        rd_slot   = cur;
        state_nxt = ST_RING;
      end
      ST_RING: begin
        rd_slot = cur;
        case (job_r.op)
          tets_pkg::OP_SLICE: begin
            r_we      = 1'b1;
            r_wdata   = slice_sum[32] ? '1 : slice_sum[31:0];
            state_nxt = ST_IDLE;
          end
          tets_pkg::OP_END: begin
            t_we          = 1'b1;
            t_wdata.tmax  = (trow_q.tmax < ring_q) ? ring_q : trow_q.tmax;
            t_wdata.sum   = end_sum[64] ? '1 : end_sum[63:0];
            t_wdata.count = (trow_q.count == '1) ? trow_q.count : trow_q.count + 1'b1;
            t_wdata.ptr   = nxt_slot;
            if (trow_q.unread < tets_pkg::UNREAD_W'(tets_pkg::RING_DEPTH)) begin
              t_wdata.unread = trow_q.unread + 1'b1;
            end
            r_we      = 1'b1;
            r_wr_addr = {job_r.task_idx, nxt_slot};
            r_wdata   = '0;
            state_nxt = ST_IDLE;
          end
          tets_pkg::OP_GET: begin
            if (out_free) begin
              load      = 1'b1;
              ld_sum    = trow_q.sum;
              ld_max    = trow_q.tmax;
              ld_cnt    = trow_q.count;
              ld_cur    = ring_q;
              state_nxt = ST_IDLE;
            end
          end
          tets_pkg::OP_CLR: begin
            if (out_free) begin
              t_we          = 1'b1;
              t_wdata.sum   = '0;
              t_wdata.tmax  = '0;
              t_wdata.count = '0;
              load          = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end
          tets_pkg::OP_TBL: begin
            if (out_free) begin
              if (job_r.table_count[4]) begin
                t_we           = 1'b1;
                t_wdata.unread = '0;
              end
              if (n_tbl == 4'd0) begin
                load      = 1'b1;
                state_nxt = ST_IDLE;
              end else begin
                rd_slot   = start;
                idx_nxt   = start;
                n_nxt     = n_tbl;
                k_nxt     = 4'd0;
                state_nxt = ST_STREAM;
              end
            end
          end
          default: begin
            if (out_free) begin
              load      = 1'b1;
              ld_stat   = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
        endcase
      end
      ST_STREAM: begin
        rd_slot = idx_r;
        if (out_free) begin
          load    = 1'b1;
          ld_val  = ring_q;
          ld_tot  = n_r;
          ld_last = (k_r + 1'b1 == n_r);
          if (ld_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = tets_pkg::slot_inc(idx_r);
            k_nxt   = k_r + 1'b1;
            rd_slot = idx_nxt;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign r_rd_addr = {job_r.task_idx, rd_slot};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    idx_r <= idx_nxt;
    n_r   <= n_nxt;
    k_r   <= k_nxt;
    if (load) begin
      ostat_r <= ld_stat;
      osum_r  <= ld_sum;
      omax_r  <= ld_max;
      ocnt_r  <= ld_cnt;
      ocur_r  <= ld_cur;
      oval_r  <= ld_val;
      otot_r  <= ld_tot;
      olast_r <= ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tmem[t_wr_addr] <= t_wdata;
    end
    trow_q <= tmem[t_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (r_we) begin
      rmem[r_wr_addr] <= r_wdata;
    end
    ring_q <= rmem[r_rd_addr];
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.status       = ostat_r;
  assign out_ch.time_sum     = osum_r;
  assign out_ch.time_max     = omax_r;
  assign out_ch.job_count    = ocnt_r;
  assign out_ch.current_time = ocur_r;
  assign out_ch.entry_value  = oval_r;
  assign out_ch.entry_total  = otot_r;
  assign out_ch.last         = olast_r;

endmodule

>>> hdl/task_execution_time_stats.sv
// Top level of the per-task job execution time monitor.
// Each word passes through the back-end sequencer steps: task row read, ring slot read, update.
// A table read then streams one entry per cycle while the output is not stalled. Results are
// registered and appear in the cycle after their update. The sequencer takes a new word only
// when through with the last, due to the registered reads of the two memories. After reset a
// clearing pass zeroes the memories, taking no input word; configuration writes are always taken.
`include "task_execution_time_stats_defines.svh"

module task_execution_time_stats (
  input  logic                        clk,
  input  logic                        rst_n,
  tets_in_if.sink                     in_ch,
  tets_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tets_pkg::APB_AW-1:0] paddr,
  input  logic [tets_pkg::APB_DW-1:0] pwdata,
  output logic [tets_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  tets_pkg::back_stat_t stat;
  tets_pkg::job_t       push_job, q_job;
  logic                 q_push, q_ready, q_pop, q_valid;

  tets_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .stat    (stat),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_job   (push_job)
  );

  tets_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_job)
  );

  tets_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_job   (q_job),
    .q_pop   (q_pop),
    .stat    (stat),
    .out_ch  (out_ch)
  );

  `TETS_ASSERT_IMPL(a_no_accept_clear, stat.clearing, !in_ch.ready, "word accepted while clearing")
  `TETS_ASSERT_IMPL(a_pop_nonempty, q_pop, q_valid, "queue popped while empty")
  `TETS_ASSERT_IMPL(a_err_last, out_ch.valid && out_ch.status, out_ch.last, "error result not last")
  `TETS_ASSERT_IMPL(a_tbl_total, out_ch.valid && !out_ch.last, out_ch.entry_total != 4'd0,
                    "non-final result without entry total")

endmodule
